>>> rtl/piab_pkg.sv
// Shared types, constants and arithmetic helpers of the particle integrate-and-bound block.
// No dependencies; used by every module under rtl/.
`default_nettype none

package piab_pkg;

	localparam int unsigned LANES               = 2;
	localparam int unsigned DIV_STEPS           = 32;
	localparam int unsigned DIV_BITS_PER_STAGE  = 4;

	localparam logic signed [31:0] GRAVITY_Q = 32'sd642908;

	localparam logic [16:0] TIME_STEP_RST    = 17'd1311;
	localparam logic [30:0] WIDTH_LIMIT_RST  = 31'd65536000;
	localparam logic [30:0] HEIGHT_LIMIT_RST = 31'd65536000;
	localparam logic [30:0] RADIUS_RST       = 31'd65536;
	localparam logic [16:0] RESTITUTION_RST  = 17'd32768;

	typedef enum logic [2:0] {
		REG_TIME_STEP    = 3'd0,
		REG_WIDTH_LIMIT  = 3'd1,
		REG_HEIGHT_LIMIT = 3'd2,
		REG_RADIUS       = 3'd3,
		REG_RESTITUTION  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		WALL_NONE = 2'd0,
		WALL_LOW  = 2'd1,
		WALL_HIGH = 2'd2
	} wall_t;

	typedef struct packed {
		logic [16:0] time_step;
		logic [30:0] width_limit;
		logic [30:0] height_limit;
		logic [30:0] radius;
		logic [16:0] restitution;
	} cfg_t;

	// Travels alongside the divider.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               neg_x;
		logic               neg_y;
		logic               ovf_x;
		logic               ovf_y;
		logic               dzero;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Divide by 2^16 (or 2^17 when half is set), rounding toward zero.
	function automatic logic signed [35:0] trunc_shr(input logic signed [51:0] v,
			input logic half);
		logic signed [51:0] bias;
		logic signed [51:0] sum;
		bias = '0;
		if (v[51])
			bias = half ? 52'sd131071 : 52'sd65535;
		sum = v + bias;
		return half ? 36'(sum >>> 17) : 36'(sum >>> 16);
	endfunction

endpackage

`default_nettype wire

>>> rtl/piab_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, with a sideband word.
// Depends on piab_pkg.
`default_nettype none

module piab_div #(
	parameter int unsigned BITS_PER_STAGE = piab_pkg::DIV_BITS_PER_STAGE,
	parameter int unsigned SIDE_W         = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [31:0]         den,
	input  wire logic [32:0]         mag [piab_pkg::LANES],
	input  wire logic [SIDE_W-1:0]   side_in,
	output logic                     out_valid,
	output logic [31:0]              quo [piab_pkg::LANES],
	output logic [SIDE_W-1:0]        side_out
);

	localparam int unsigned STAGES = piab_pkg::DIV_STEPS / BITS_PER_STAGE;

	logic              vld_s  [STAGES+1];
	logic [31:0]       den_s  [STAGES+1];
	logic [SIDE_W-1:0] side_s [STAGES+1];
	logic [31:0]       rem_s  [piab_pkg::LANES][STAGES+1];
	logic [31:0]       low_s  [piab_pkg::LANES][STAGES+1];
	logic [31:0]       q_s    [piab_pkg::LANES][STAGES+1];

	assign vld_s[0]  = in_valid;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar ln = 0; ln < piab_pkg::LANES; ln++) begin : g_init
		// numerator is mag * 2^16; start with its bits above the quotient range
		assign rem_s[ln][0] = {15'd0, mag[ln][32:16]};
		assign low_s[ln][0] = {mag[ln][15:0], 16'd0};
		assign q_s[ln][0]   = '0;
	end

	for (genvar st = 0; st < STAGES; st++) begin : g_stage
		logic [31:0] rem_nx [piab_pkg::LANES];
		logic [31:0] low_nx [piab_pkg::LANES];
		logic [31:0] q_nx   [piab_pkg::LANES];

		always_comb begin
			logic [32:0] t;
			for (int ln = 0; ln < piab_pkg::LANES; ln++) begin
				rem_nx[ln] = rem_s[ln][st];
				low_nx[ln] = low_s[ln][st];
				q_nx[ln]   = q_s[ln][st];
				for (int b = 0; b < BITS_PER_STAGE; b++) begin
					t = {rem_nx[ln], low_nx[ln][31]};
					low_nx[ln] = {low_nx[ln][30:0], 1'b0};
					if (t >= {1'b0, den_s[st]}) begin
						rem_nx[ln] = 32'(t - {1'b0, den_s[st]});
						q_nx[ln]   = {q_nx[ln][30:0], 1'b1};
					end else begin
						rem_nx[ln] = t[31:0];
						q_nx[ln]   = {q_nx[ln][30:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[st+1] <= 1'b0;
			else if (en)
				vld_s[st+1] <= vld_s[st];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[st+1]  <= den_s[st];
				side_s[st+1] <= side_s[st];
			end
		end

		for (genvar ln = 0; ln < piab_pkg::LANES; ln++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[ln][st+1] <= rem_nx[ln];
					low_s[ln][st+1] <= low_nx[ln];
					q_s[ln][st+1]   <= q_nx[ln];
				end
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign side_out  = side_s[STAGES];
	for (genvar ln = 0; ln < piab_pkg::LANES; ln++) begin : g_out
		assign quo[ln] = q_s[ln][STAGES];
	end

endmodule

`default_nettype wire

>>> rtl/piab_bound.sv
// Wall clamp and velocity reflection, five pipeline stages ending in the output register.
// Depends on piab_pkg.
`default_nettype none

module piab_bound (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire piab_pkg::cfg_t      cfg,
	input  wire logic                in_valid,
	input  wire logic signed [31:0]  px,
	input  wire logic signed [31:0]  py,
	input  wire logic signed [31:0]  vx,
	input  wire logic signed [31:0]  vy,
	input  wire logic                dzero,
	output logic                     out_valid,
	output logic signed [31:0]       new_pos_x,
	output logic signed [31:0]       new_pos_y,
	output logic signed [31:0]       new_vel_x,
	output logic signed [31:0]       new_vel_y,
	output logic [1:0]               wall_x,
	output logic [1:0]               wall_y,
	output logic                     no_density
);

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0]   px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic signed [31:0]   vx_s1, vy_s1, vx_s2, vy_s2, vx_s3, vy_s3, vx_s4, vy_s4;
	piab_pkg::wall_t      wx_s1, wy_s1, wx_s2, wy_s2, wx_s3, wy_s3, wx_s4, wy_s4;
	logic                 dz_s1, dz_s2, dz_s3, dz_s4;
	logic signed [33:0]   m_s2;
	logic                 corner_s2, corner_s3;
	logic signed [51:0]   km_s3;
	logic signed [35:0]   d_s4;

	logic signed [31:0]   r32, hi_x, hi_y;
	logic signed [31:0]   px_c, py_c;
	piab_pkg::wall_t      wx_c, wy_c;
	logic signed [33:0]   tx, ty;
	logic [17:0]          k;
	logic signed [52:0]   km_full;
	logic signed [31:0]   vx_r, vy_r;

	assign r32  = $signed({1'b0, cfg.radius});
	assign hi_x = $signed({1'b0, cfg.width_limit}) - r32;
	assign hi_y = $signed({1'b0, cfg.height_limit}) - r32;

	// low wall test takes priority over high wall test
	always_comb begin
		px_c = px;
		wx_c = piab_pkg::WALL_NONE;
		if (px < r32) begin
			px_c = r32;
			wx_c = piab_pkg::WALL_LOW;
		end else if (px > hi_x) begin
			px_c = hi_x;
			wx_c = piab_pkg::WALL_HIGH;
		end
		py_c = py;
		wy_c = piab_pkg::WALL_NONE;
		if (py < r32) begin
			py_c = r32;
			wy_c = piab_pkg::WALL_LOW;
		end else if (py > hi_y) begin
			py_c = hi_y;
			wy_c = piab_pkg::WALL_HIGH;
		end
	end

	// normal component of velocity, signed by wall side
	always_comb begin
		case (wx_s1)
			piab_pkg::WALL_LOW:  tx = 34'(vx_s1);
			piab_pkg::WALL_HIGH: tx = -34'(vx_s1);
			default:             tx = '0;
		endcase
		case (wy_s1)
			piab_pkg::WALL_LOW:  ty = 34'(vy_s1);
			piab_pkg::WALL_HIGH: ty = -34'(vy_s1);
			default:             ty = '0;
		endcase
	end

	assign k       = 18'(17'd65536) + 18'(cfg.restitution);
	assign km_full = $signed({1'b0, k}) * 53'(m_s2);

	always_comb begin
		case (wx_s4)
			piab_pkg::WALL_LOW:  vx_r = piab_pkg::sat32(40'(vx_s4) - 40'(d_s4));
			piab_pkg::WALL_HIGH: vx_r = piab_pkg::sat32(40'(vx_s4) + 40'(d_s4));
			default:             vx_r = vx_s4;
		endcase
		case (wy_s4)
			piab_pkg::WALL_LOW:  vy_r = piab_pkg::sat32(40'(vy_s4) - 40'(d_s4));
			piab_pkg::WALL_HIGH: vy_r = piab_pkg::sat32(40'(vy_s4) + 40'(d_s4));
			default:             vy_r = vy_s4;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_c;
			py_s1 <= py_c;
			vx_s1 <= vx;
			vy_s1 <= vy;
			wx_s1 <= wx_c;
			wy_s1 <= wy_c;
			dz_s1 <= dzero;

			px_s2     <= px_s1;
			py_s2     <= py_s1;
			vx_s2     <= vx_s1;
			vy_s2     <= vy_s1;
			wx_s2     <= wx_s1;
			wy_s2     <= wy_s1;
			dz_s2     <= dz_s1;
			m_s2      <= tx + ty;
			corner_s2 <= (wx_s1 != piab_pkg::WALL_NONE) && (wy_s1 != piab_pkg::WALL_NONE);

			px_s3     <= px_s2;
			py_s3     <= py_s2;
			vx_s3     <= vx_s2;
			vy_s3     <= vy_s2;
			wx_s3     <= wx_s2;
			wy_s3     <= wy_s2;
			dz_s3     <= dz_s2;
			corner_s3 <= corner_s2;
			km_s3     <= km_full[51:0];

			px_s4 <= px_s3;
			py_s4 <= py_s3;
			vx_s4 <= vx_s3;
			vy_s4 <= vy_s3;
			wx_s4 <= wx_s3;
			wy_s4 <= wy_s3;
			dz_s4 <= dz_s3;
			d_s4  <= piab_pkg::trunc_shr(km_s3, corner_s3);

			new_pos_x  <= px_s4;
			new_pos_y  <= py_s4;
			new_vel_x  <= vx_r;
			new_vel_y  <= vy_r;
			wall_x     <= wx_s4;
			wall_y     <= wy_s4;
			no_density <= dz_s4;
		end
	end

	assign out_valid = v_s5;

endmodule

`default_nettype wire

>>> rtl/particle_integrate_and_bound.sv
// Particle integrate-and-bound: force/density, symplectic Euler step, wall clamp and reflection.
// The pipeline depth depends on DIV_BITS_PER_STAGE, which sets the number of divider stages.
// Throughput: one particle per cycle; the whole pipeline holds while the output is stalled.
// Reset: asynchronous, clears all valid bits and loads the register defaults.
// Depends on piab_pkg, piab_div and piab_bound.
`default_nettype none

module particle_integrate_and_bound #(
	parameter int unsigned DIV_BITS_PER_STAGE = piab_pkg::DIV_BITS_PER_STAGE
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [30:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [31:0]  vel_x,
	input  wire logic signed [31:0]  vel_y,
	input  wire logic signed [31:0]  pressure_x,
	input  wire logic signed [31:0]  pressure_y,
	input  wire logic signed [31:0]  viscous_x,
	input  wire logic signed [31:0]  viscous_y,
	input  wire logic [31:0]         density,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       new_pos_x,
	output logic signed [31:0]       new_pos_y,
	output logic signed [31:0]       new_vel_x,
	output logic signed [31:0]       new_vel_y,
	output logic [1:0]               wall_x,
	output logic [1:0]               wall_y,
	output logic                     no_density
);

	localparam int unsigned SIDE_W = $bits(piab_pkg::side_t);

	piab_pkg::cfg_t cfg_q;
	logic           en;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step    <= piab_pkg::TIME_STEP_RST;
			cfg_q.width_limit  <= piab_pkg::WIDTH_LIMIT_RST;
			cfg_q.height_limit <= piab_pkg::HEIGHT_LIMIT_RST;
			cfg_q.radius       <= piab_pkg::RADIUS_RST;
			cfg_q.restitution  <= piab_pkg::RESTITUTION_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				piab_pkg::REG_TIME_STEP:    cfg_q.time_step    <= cfg_data[16:0];
				piab_pkg::REG_WIDTH_LIMIT:  cfg_q.width_limit  <= cfg_data;
				piab_pkg::REG_HEIGHT_LIMIT: cfg_q.height_limit <= cfg_data;
				piab_pkg::REG_RADIUS:       cfg_q.radius       <= cfg_data;
				piab_pkg::REG_RESTITUTION:  cfg_q.restitution  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// ---- front end: force sums, magnitudes, overflow test ----
	logic                 v_s1, v_s2;
	logic signed [31:0]   px_s1, py_s1, vx_s1, vy_s1;
	logic signed [32:0]   fx_s1, fy_s1;
	logic [31:0]          dens_s1, dens_s2;
	logic [32:0]          mag_s2 [piab_pkg::LANES];
	piab_pkg::side_t      side_s2;
	logic [32:0]          mag_x_c, mag_y_c;

	assign mag_x_c = fx_s1[32] ? 33'(-fx_s1) : 33'(fx_s1);
	assign mag_y_c = fy_s1[32] ? 33'(-fy_s1) : 33'(fy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			vx_s1   <= vel_x;
			vy_s1   <= vel_y;
			fx_s1   <= 33'(pressure_x) + 33'(viscous_x);
			fy_s1   <= 33'(pressure_y) + 33'(viscous_y);
			dens_s1 <= density;

			side_s2.px    <= px_s1;
			side_s2.py    <= py_s1;
			side_s2.vx    <= vx_s1;
			side_s2.vy    <= vy_s1;
			side_s2.neg_x <= fx_s1[32];
			side_s2.neg_y <= fy_s1[32];
			// quotient reaches 2^31 exactly when mag >= density * 2^15
			side_s2.ovf_x <= {14'd0, mag_x_c} >= {dens_s1, 15'd0};
			side_s2.ovf_y <= {14'd0, mag_y_c} >= {dens_s1, 15'd0};
			side_s2.dzero <= dens_s1 == '0;
			mag_s2[0]     <= mag_x_c;
			mag_s2[1]     <= mag_y_c;
			dens_s2       <= dens_s1;
		end
	end

	// ---- divider ----
	logic              div_valid;
	logic [31:0]       quo [piab_pkg::LANES];
	logic [SIDE_W-1:0] side_raw;
	piab_pkg::side_t   dside;

	piab_div #(
		.BITS_PER_STAGE(DIV_BITS_PER_STAGE),
		.SIDE_W        (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.den      (dens_s2),
		.mag      (mag_s2),
		.side_in  (side_s2),
		.out_valid(div_valid),
		.quo      (quo),
		.side_out (side_raw)
	);

	assign dside = piab_pkg::side_t'(side_raw);

	// ---- integration ----
	logic signed [31:0] ax_c, ay_c;

	always_comb begin
		if (dside.dzero)
			ax_c = '0;
		else if (dside.ovf_x)
			ax_c = dside.neg_x ? 32'sh80000000 : 32'sh7fffffff;
		else
			ax_c = dside.neg_x ? -$signed(quo[0]) : $signed(quo[0]);
		if (dside.dzero)
			ay_c = '0;
		else if (dside.ovf_y)
			ay_c = dside.neg_y ? 32'sh80000000 : 32'sh7fffffff;
		else
			ay_c = dside.neg_y ? -$signed(quo[1]) : $signed(quo[1]);
	end

	logic                v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [31:0]  px_s3, py_s3, px_s4, py_s4, px_s5, py_s5, px_s6, py_s6;
	logic signed [31:0]  px_s7, py_s7, px_s8, py_s8;
	logic signed [31:0]  vx_s3, vy_s3, vx_s4, vy_s4, vx_s5, vy_s5, vx_s6, vy_s6;
	logic signed [31:0]  vx_s7, vy_s7, vx_s8, vy_s8;
	logic                dz_s3, dz_s4, dz_s5, dz_s6, dz_s7, dz_s8;
	logic signed [31:0]  ax_s3, ay_s3, ax_s4, ay_s4;
	logic signed [49:0]  pax_s5, pay_s5, ppx_s7, ppy_s7;
	logic signed [17:0]  dt_s;

	assign dt_s = $signed({1'b0, cfg_q.time_step});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s3 <= div_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= dside.px;
			py_s3 <= dside.py;
			vx_s3 <= dside.vx;
			vy_s3 <= dside.vy;
			dz_s3 <= dside.dzero;
			ax_s3 <= ax_c;
			ay_s3 <= ay_c;

			px_s4 <= px_s3;
			py_s4 <= py_s3;
			vx_s4 <= vx_s3;
			vy_s4 <= vy_s3;
			dz_s4 <= dz_s3;
			ax_s4 <= ax_s3;
			ay_s4 <= piab_pkg::sat32(40'(ay_s3) - 40'(piab_pkg::GRAVITY_Q));

			px_s5  <= px_s4;
			py_s5  <= py_s4;
			vx_s5  <= vx_s4;
			vy_s5  <= vy_s4;
			dz_s5  <= dz_s4;
			pax_s5 <= 50'(ax_s4) * 50'(dt_s);
			pay_s5 <= 50'(ay_s4) * 50'(dt_s);

			px_s6 <= px_s5;
			py_s6 <= py_s5;
			dz_s6 <= dz_s5;
			vx_s6 <= piab_pkg::sat32(40'(vx_s5) + 40'(piab_pkg::trunc_shr(52'(pax_s5), 1'b0)));
			vy_s6 <= piab_pkg::sat32(40'(vy_s5) + 40'(piab_pkg::trunc_shr(52'(pay_s5), 1'b0)));

			px_s7  <= px_s6;
			py_s7  <= py_s6;
			vx_s7  <= vx_s6;
			vy_s7  <= vy_s6;
			dz_s7  <= dz_s6;
			ppx_s7 <= 50'(vx_s6) * 50'(dt_s);
			ppy_s7 <= 50'(vy_s6) * 50'(dt_s);

			vx_s8 <= vx_s7;
			vy_s8 <= vy_s7;
			dz_s8 <= dz_s7;
			px_s8 <= piab_pkg::sat32(40'(px_s7) + 40'(piab_pkg::trunc_shr(52'(ppx_s7), 1'b0)));
			py_s8 <= piab_pkg::sat32(40'(py_s7) + 40'(piab_pkg::trunc_shr(52'(ppy_s7), 1'b0)));
		end
	end

	// ---- clamp and reflect ----
	piab_bound u_bound (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (v_s8),
		.px        (px_s8),
		.py        (py_s8),
		.vx        (vx_s8),
		.vy        (vy_s8),
		.dzero     (dz_s8),
		.out_valid (out_valid),
		.new_pos_x (new_pos_x),
		.new_pos_y (new_pos_y),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y),
		.wall_x    (wall_x),
		.wall_y    (wall_y),
		.no_density(no_density)
	);

	// ---- assertions ----
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted transfer did not enter the first stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s2) && $stable(v_s8)))
		else $error("pipeline moved while the output was stalled");

	a_zero_density: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1 && dens_s1 == '0) |=> (v_s2 && side_s2.dzero))
		else $error("zero density not flagged");

endmodule

`default_nettype wire
